/* sv/cspd_pkg.sv */
`timescale 1ns / 1ps
// shared constants for the distinct-powers counter
// no dependencies
package cspd_pkg;

  localparam int VALUE_BITS_DEFAULT = 31;
  localparam int BINOM_W            = 32;
  localparam int K_BITS             = 5;
  localparam int ROM_COLS           = 32;
  localparam int BASE_W             = 4;
  localparam int COUNT_W            = 32;
  localparam int APB_DATA_W         = 32;
  localparam int APB_ADDR_W         = 3;

  localparam logic [BASE_W-1:0] BASE_RESET = 4'd2;
  localparam logic [BASE_W-1:0] BASE_MIN   = 4'd2;
  localparam logic [K_BITS-1:0] ONES_RESET = 5'd1;

  // register index, taken from paddr[2]
  localparam logic REG_NUMBER_BASE = 1'b0;
  localparam logic REG_ONES_WANTED = 1'b1;

endpackage

/* sv/cspd_ram.sv */
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies
module cspd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/cspd_pascal_fill.sv */
`timescale 1ns / 1ps
// after reset builds the pascal triangle row by row and writes it into the binomial ram
// depends on cspd_pkg
module cspd_pascal_fill
  import cspd_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
  input  logic                                     clk,
  input  logic                                     rst,
  output logic                                     we,
  output logic [$clog2(VALUE_BITS)+K_BITS-1:0]     waddr,
  output logic [BINOM_W-1:0]                       wdata,
  output logic                                     filling
);

  localparam int RB = $clog2(VALUE_BITS);

  logic [BINOM_W-1:0] row_val [ROM_COLS];
  logic [RB-1:0]      row;
  logic [K_BITS-1:0]  col;

  assign we    = filling;
  assign waddr = {row, col};
  assign wdata = row_val[col];

  always_ff @(posedge clk) begin
    if (rst) begin
      filling <= 1'b1;
      row     <= '0;
      col     <= '0;
      for (int j = 0; j < ROM_COLS; j++) begin
        row_val[j] <= (j == 0) ? BINOM_W'(1) : '0;
      end
    end else if (filling) begin
      col <= col + 1'b1;
      if (col == K_BITS'(ROM_COLS - 1)) begin
        for (int j = 1; j < ROM_COLS; j++) begin
          row_val[j] <= row_val[j] + row_val[j-1];
        end
        if (row == RB'(VALUE_BITS - 1)) begin
          filling <= 1'b0;
        end else begin
          row <= row + 1'b1;
        end
      end
    end
  end

endmodule

/* sv/cspd_prefix.sv */
`timescale 1ns / 1ps
// prefix counter: walks base digits of one bound with a shared multiplier, adds binomials
// depends on cspd_pkg, reads the binomial ram through rom_addr / rom_data
module cspd_prefix
  import cspd_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 go,
  input  logic [VALUE_BITS-1:0]                bound,
  input  logic [BASE_W-1:0]                    base,
  input  logic [K_BITS-1:0]                    ones_wanted,
  output logic [$clog2(VALUE_BITS)+K_BITS-1:0] rom_addr,
  input  logic [BINOM_W-1:0]                   rom_data,
  output logic                                 done,
  output logic [COUNT_W-1:0]                   count
);

  localparam int WW = VALUE_BITS + BASE_W;
  localparam int PB = $clog2(VALUE_BITS + 1);
  localparam int RB = $clog2(VALUE_BITS);

  localparam logic [2:0] P_IDLE = 3'd0;
  localparam logic [2:0] P_UP   = 3'd1;
  localparam logic [2:0] P_DIG  = 3'd2;
  localparam logic [2:0] P_ACC1 = 3'd3;
  localparam logic [2:0] P_ACC2 = 3'd4;
  localparam logic [2:0] P_FIN  = 3'd5;
  localparam logic [2:0] P_RET  = 3'd6;

  logic [2:0]            state;
  logic [VALUE_BITS-1:0] bnd;
  logic [WW-1:0]         weight;
  logic [WW-1:0]         topw;
  logic [WW-1:0]         rest;
  logic [PB-1:0]         pos;
  logic [K_BITS-1:0]     left;
  logic [COUNT_W-1:0]    total;
  logic                  big;

  logic [WW-1:0]         mul_a;
  logic [WW+BASE_W-1:0]  prod;
  logic [WW-1:0]         mul_next;
  logic                  lt1;
  logic                  lt2;
  logic [RB-1:0]         row;

  // shared multiplier: operand times base
  always_comb begin
    unique case (state)
      P_UP:    mul_a = weight;
      P_ACC1:  mul_a = rest - topw;
      default: mul_a = rest;
    endcase
  end

  assign prod     = {{BASE_W{1'b0}}, mul_a} * {{WW{1'b0}}, base};
  assign mul_next = prod[WW-1:0];
  assign lt1      = rest < topw;
  assign lt2      = {1'b0, rest} < {topw, 1'b0};
  assign row      = pos[RB-1:0];
  assign rom_addr = (state == P_ACC1) ? {row, left - 1'b1} : {row, left};
  assign done     = (state == P_RET);
  assign count    = total;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= P_IDLE;
    end else begin
      unique case (state)
        P_IDLE: begin
          if (go) begin
            bnd    <= bound;
            weight <= WW'(1);
            rest   <= {{BASE_W{1'b0}}, bound};
            pos    <= '0;
            left   <= ones_wanted;
            total  <= '0;
            state  <= P_UP;
          end
        end
        P_UP: begin
          if (weight <= {{BASE_W{1'b0}}, bnd}) begin
            topw   <= weight;
            weight <= mul_next;
            pos    <= pos + 1'b1;
          end else if (pos == '0) begin
            state <= P_FIN;
          end else begin
            pos   <= pos - 1'b1;
            state <= P_DIG;
          end
        end
        P_DIG: begin
          if (lt1) begin
            rest <= mul_next;
            if (pos == '0) begin
              state <= P_FIN;
            end else begin
              pos <= pos - 1'b1;
            end
          end else begin
            big   <= !lt2;
            state <= P_ACC1;
          end
        end
        P_ACC1: begin
          total <= total + rom_data;
          if (big) begin
            state <= (left != '0) ? P_ACC2 : P_RET;
          end else if (left == '0) begin
            state <= P_RET;
          end else begin
            left <= left - 1'b1;
            rest <= mul_next;
            if (pos == '0) begin
              state <= P_FIN;
            end else begin
              pos   <= pos - 1'b1;
              state <= P_DIG;
            end
          end
        end
        P_ACC2: begin
          total <= total + rom_data;
          state <= P_RET;
        end
        P_FIN: begin
          if (left == '0) begin
            total <= total + 1'b1;
          end
          state <= P_RET;
        end
        P_RET: begin
          state <= P_IDLE;
        end
        default: begin
          state <= P_IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/count_sums_of_distinct_powers.sv */
`timescale 1ns / 1ps
// top level: apb registers, range sequencing, binomial ram, fill and prefix units
// depends on cspd_pkg, cspd_ram, cspd_pascal_fill, cspd_prefix
//
// Counts the integers in [lower_bound, upper_bound] whose base-B digits are all 0 or 1
// with exactly K ones. A transaction is taken when start is high and busy is low; the
// count appears on match_count with done high for exactly one cycle and cannot be held
// off. After reset the binomial ram is filled with busy high. A transaction runs one or
// two prefix counts on one shared multiplier; each first finds the digit count n of the
// bound, then walks its digits from the top. An empty range answers in the cycle after
// it is taken.
module count_sums_of_distinct_powers
  import cspd_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready,
  input  logic                   start,
  output logic                   busy,
  input  logic [VALUE_BITS-1:0]  lower_bound,
  input  logic [VALUE_BITS-1:0]  upper_bound,
  output logic                   done,
  output logic [COUNT_W-1:0]     match_count
);

  localparam int RB    = $clog2(VALUE_BITS);
  localparam int AW    = RB + K_BITS;
  localparam int DEPTH = (1 << RB) * ROM_COLS;

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_HIW  = 2'd1;
  localparam logic [1:0] T_LO   = 2'd2;
  localparam logic [1:0] T_LOW  = 2'd3;

  logic [BASE_W-1:0]     number_base;
  logic [K_BITS-1:0]     ones_wanted;
  logic [BASE_W-1:0]     eff_base;
  logic [1:0]            state;
  logic [VALUE_BITS-1:0] lo;
  logic [COUNT_W-1:0]    hi_count;

  logic                  fill_we;
  logic [AW-1:0]         fill_addr;
  logic [BINOM_W-1:0]    fill_data;
  logic                  filling;
  logic [AW-1:0]         rom_addr;
  logic [BINOM_W-1:0]    rom_data;

  logic                  pfx_go;
  logic [VALUE_BITS-1:0] pfx_bound;
  logic                  pfx_done;
  logic [COUNT_W-1:0]    pfx_count;
  logic                  accept;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ONES_WANTED) ? APB_DATA_W'(ones_wanted)
                                                : APB_DATA_W'(number_base);

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= BASE_RESET;
      ones_wanted <= ONES_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_NUMBER_BASE: number_base <= pwdata[BASE_W-1:0];
        REG_ONES_WANTED: ones_wanted <= pwdata[K_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign eff_base = (number_base < BASE_MIN) ? BASE_MIN : number_base;

  cspd_ram #(
    .WIDTH (BINOM_W),
    .DEPTH (DEPTH)
  ) u_binom_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_addr),
    .wdata (fill_data),
    .raddr (rom_addr),
    .rdata (rom_data)
  );

  cspd_pascal_fill #(
    .VALUE_BITS (VALUE_BITS)
  ) u_fill (
    .clk     (clk),
    .rst     (rst),
    .we      (fill_we),
    .waddr   (fill_addr),
    .wdata   (fill_data),
    .filling (filling)
  );

  cspd_prefix #(
    .VALUE_BITS (VALUE_BITS)
  ) u_prefix (
    .clk         (clk),
    .rst         (rst),
    .go          (pfx_go),
    .bound       (pfx_bound),
    .base        (eff_base),
    .ones_wanted (ones_wanted),
    .rom_addr    (rom_addr),
    .rom_data    (rom_data),
    .done        (pfx_done),
    .count       (pfx_count)
  );

  assign busy      = filling || (state != T_IDLE);
  assign accept    = start && !busy;
  assign pfx_go    = (accept && (lower_bound <= upper_bound)) || (state == T_LO);
  assign pfx_bound = (state == T_LO) ? lo - 1'b1 : upper_bound;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        T_IDLE: begin
          if (accept) begin
            lo <= lower_bound;
            if (lower_bound > upper_bound) begin
              match_count <= '0;
              done        <= 1'b1;
            end else begin
              state <= T_HIW;
            end
          end
        end
        T_HIW: begin
          if (pfx_done) begin
            if (lo == '0) begin
              match_count <= pfx_count;
              done        <= 1'b1;
              state       <= T_IDLE;
            end else begin
              hi_count <= pfx_count;
              state    <= T_LO;
            end
          end
        end
        T_LO: begin
          state <= T_LOW;
        end
        T_LOW: begin
          if (pfx_done) begin
            match_count <= hi_count - pfx_count;
            done        <= 1'b1;
            state       <= T_IDLE;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

endmodule
